[rtl/fbc_pkg.sv]
// Package for the frustum box cull block: opcodes, sizes, and the
// controller/datapath command and status types. No dependencies.
package fbc_pkg;

    localparam int NUM_PLANES_DEF  = 6;
    localparam int NUM_CORNERS     = 8;
    localparam int COORD_BITS_DEF  = 24;
    localparam int OPCODE_W        = 2;
    localparam int SLOT_W          = 3;
    localparam int AXES            = 3;

    localparam logic [OPCODE_W-1:0] OP_LOAD_PLANE  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD_CORNER = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_TEST_BOX    = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_UNUSED      = 2'd3;

    typedef struct packed {
        logic              accept;    // request taken this cycle
        logic              plane_go;  // issue products for plane_idx
        logic [SLOT_W-1:0] plane_idx;
        logic              axis_go;   // corner check on axis_idx
        logic [1:0]        axis_idx;
        logic              finish;    // place the test answer in the output register
    } fbc_cmd_t;

    typedef struct packed {
        logic out_busy;
    } fbc_stat_t;

endpackage

[rtl/fbc_ctrl.sv]
// Sequencer for the frustum box cull block.
// Depends on fbc_pkg; drives fbc_dp through fbc_cmd_t.
module fbc_ctrl #(
    parameter int NUM_PLANES = fbc_pkg::NUM_PLANES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [fbc_pkg::OPCODE_W-1:0]  opcode,
    input  fbc_pkg::fbc_stat_t            stat,
    output fbc_pkg::fbc_cmd_t             cmd
);
    import fbc_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PLANE = 2'd1;
    localparam logic [1:0] S_AXIS  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    localparam logic [SLOT_W-1:0] LAST_PLANE = SLOT_W'(NUM_PLANES - 1);

    logic [1:0]        state_reg, state_next;
    logic [SLOT_W-1:0] cnt_reg, cnt_next;
    logic              accept;

    assign in_stall = (state_reg != S_IDLE) || stat.out_busy;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd           = '0;
        cmd.accept    = accept;
        cmd.plane_idx = cnt_reg;
        cmd.axis_idx  = cnt_reg[1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && opcode == OP_TEST_BOX)
                begin
                    state_next = S_PLANE;
                    cnt_next   = '0;
                end
            end
            S_PLANE:
            begin
                cmd.plane_go = 1'b1;
                if (cnt_reg == LAST_PLANE)
                begin
                    state_next = S_AXIS;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_AXIS:
            begin
                cmd.axis_go = 1'b1;
                if (cnt_reg == SLOT_W'(AXES - 1))
                    state_next = S_DONE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[rtl/fbc_dp.sv]
// Datapath for the frustum box cull block: plane and corner stores, the
// per-plane nearest-corner distance, the corner-axis check and the output register.
// Depends on fbc_pkg; commanded by fbc_ctrl.
module fbc_dp #(
    parameter int NUM_PLANES = fbc_pkg::NUM_PLANES_DEF,
    parameter int COORD_BITS = fbc_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fbc_pkg::fbc_cmd_t             cmd,
    output fbc_pkg::fbc_stat_t            stat,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic [fbc_pkg::OPCODE_W-1:0]  opcode,
    input  logic [fbc_pkg::SLOT_W-1:0]    slot,
    input  logic signed [COORD_BITS-1:0]  p_x,
    input  logic signed [COORD_BITS-1:0]  p_y,
    input  logic signed [COORD_BITS-1:0]  p_z,
    input  logic signed [COORD_BITS-1:0]  plane_offset,
    input  logic signed [COORD_BITS-1:0]  q_x,
    input  logic signed [COORD_BITS-1:0]  q_y,
    input  logic signed [COORD_BITS-1:0]  q_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          is_answer,
    output logic                          visible
);
    import fbc_pkg::*;

    localparam int PW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
    localparam int MW = 2 * COORD_BITS;
    localparam int SW = 2 * COORD_BITS + 3;

    logic signed [COORD_BITS-1:0] plane_reg  [NUM_PLANES][4];
    logic signed [COORD_BITS-1:0] corner_reg [NUM_CORNERS][AXES];
    logic signed [COORD_BITS-1:0] mn_reg [AXES];
    logic signed [COORD_BITS-1:0] mx_reg [AXES];
    logic signed [MW-1:0]         prod_reg [AXES];
    logic signed [MW-1:0]         prod_next [AXES];
    logic signed [COORD_BITS-1:0] off_reg;
    logic                         pv_reg;
    logic                         culled_reg, culled_next;
    logic                         cce_reg;
    logic                         out_valid_reg, is_answer_reg, visible_reg;
    logic signed [SW-1:0]         pdist;
    logic [PW-1:0]                pidx;
    logic [NUM_CORNERS-1:0]       above, below;
    logic                         ax_cull;

    assign pidx = cmd.plane_idx[PW-1:0];

    // nearest corner per axis: smallest n*x takes the lower of min and max
    // for n >= 0, else the higher; an inverted box is reordered per axis
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            if (plane_reg[pidx][a][COORD_BITS-1] != (mn_reg[a] > mx_reg[a]))
                prod_next[a] = plane_reg[pidx][a] * mx_reg[a];
            else
                prod_next[a] = plane_reg[pidx][a] * mn_reg[a];
        end
    end

    assign pdist = SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2])
                 + {{(SW-COORD_BITS-12){off_reg[COORD_BITS-1]}}, off_reg, 12'b0};

    always_comb
    begin
        for (int c = 0; c < NUM_CORNERS; c++)
        begin
            above[c] = corner_reg[c][cmd.axis_idx] > mx_reg[cmd.axis_idx];
            below[c] = corner_reg[c][cmd.axis_idx] < mn_reg[cmd.axis_idx];
        end
        ax_cull = cce_reg && ((&above) || (&below));
    end

    always_comb
    begin
        culled_next = culled_reg;
        if (pv_reg && !pdist[SW-1])
            culled_next = 1'b1;
        if (cmd.axis_go && ax_cull)
            culled_next = 1'b1;
        if (cmd.accept)
            culled_next = 1'b0;
    end

    // stores and operands
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            if (opcode == OP_LOAD_PLANE && {1'b0, slot} < 4'(NUM_PLANES))
            begin
                plane_reg[slot[PW-1:0]][0] <= p_x;
                plane_reg[slot[PW-1:0]][1] <= p_y;
                plane_reg[slot[PW-1:0]][2] <= p_z;
                plane_reg[slot[PW-1:0]][3] <= plane_offset;
            end
            if (opcode == OP_LOAD_CORNER)
            begin
                corner_reg[slot][0] <= p_x;
                corner_reg[slot][1] <= p_y;
                corner_reg[slot][2] <= p_z;
            end
            if (opcode == OP_TEST_BOX)
            begin
                mn_reg[0] <= p_x;
                mn_reg[1] <= p_y;
                mn_reg[2] <= p_z;
                mx_reg[0] <= q_x;
                mx_reg[1] <= q_y;
                mx_reg[2] <= q_z;
            end
        end
        if (cmd.plane_go)
        begin
            for (int a = 0; a < AXES; a++)
                prod_reg[a] <= prod_next[a];
            off_reg <= plane_reg[pidx][3];
        end
        if ((cmd.accept && opcode != OP_TEST_BOX) || cmd.finish)
        begin
            is_answer_reg <= cmd.finish;
            visible_reg   <= cmd.finish && !culled_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg        <= 1'b0;
            culled_reg    <= 1'b0;
            cce_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pv_reg     <= cmd.plane_go;
            culled_reg <= culled_next;
            if (cfg_wr_en)
                cce_reg <= cfg_wr_data;
            if ((cmd.accept && opcode != OP_TEST_BOX) || cmd.finish)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign stat.out_busy = out_valid_reg && out_stall;
    assign out_valid     = out_valid_reg;
    assign is_answer     = is_answer_reg;
    assign visible       = visible_reg;

endmodule

[rtl/frustum_box_cull_test.sv]
// Top level of the frustum box cull block: fbc_ctrl sequences fbc_dp.
// Depends on fbc_pkg, fbc_ctrl and fbc_dp.
//
// Loads (planes, frustum corners) take one request and answer in the next
// cycle with is_answer low. A box test runs one plane per cycle, where the
// nearest box corner's distance is formed with three multipliers and summed the
// cycle after, then the frustum-corner check axis by axis, then the answer is
// registered once the output register is not stalled. The next request can be
// taken once the answer is registered, so a test holds the input until then. One
// request is in flight at a time; a finished answer waits in the output register
// while the next request is taken once it leaves.
module frustum_box_cull_test #(
    parameter int NUM_PLANES = fbc_pkg::NUM_PLANES_DEF,
    parameter int COORD_BITS = fbc_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [fbc_pkg::OPCODE_W-1:0]  opcode,
    input  logic [fbc_pkg::SLOT_W-1:0]    slot,
    input  logic signed [COORD_BITS-1:0]  p_x,
    input  logic signed [COORD_BITS-1:0]  p_y,
    input  logic signed [COORD_BITS-1:0]  p_z,
    input  logic signed [COORD_BITS-1:0]  plane_offset,
    input  logic signed [COORD_BITS-1:0]  q_x,
    input  logic signed [COORD_BITS-1:0]  q_y,
    input  logic signed [COORD_BITS-1:0]  q_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          is_answer,
    output logic                          visible
);
    import fbc_pkg::*;

    fbc_cmd_t  cmd;
    fbc_stat_t stat;

    fbc_ctrl #(.NUM_PLANES(NUM_PLANES)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .opcode   (opcode),
        .stat     (stat),
        .cmd      (cmd)
    );

    fbc_dp #(.NUM_PLANES(NUM_PLANES), .COORD_BITS(COORD_BITS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .opcode       (opcode),
        .slot         (slot),
        .p_x          (p_x),
        .p_y          (p_y),
        .p_z          (p_z),
        .plane_offset (plane_offset),
        .q_x          (q_x),
        .q_y          (q_y),
        .q_z          (q_z),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_answer    (is_answer),
        .visible      (visible)
    );

endmodule

[rtl/fbc_checker.sv]
// Port-level checks for frustum_box_cull_test, bound to the top level.
// Depends on fbc_pkg.
module fbc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [fbc_pkg::OPCODE_W-1:0]  opcode,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          is_answer,
    input logic                          visible
);
    import fbc_pkg::*;

    // a load is answered in the next cycle, as an acknowledge
    a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && opcode != OP_TEST_BOX |=> out_valid && !is_answer)
        else $error("load request not acknowledged");

    // a test stalls the input once it is taken
    a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && opcode == OP_TEST_BOX |=> in_stall)
        else $error("request taken during a box test");

    a_ack_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_answer |-> !visible)
        else $error("acknowledge shows visible");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(is_answer) && $stable(visible))
        else $error("stalled result changed");

endmodule

bind frustum_box_cull_test fbc_checker u_fbc_checker (.*);

[sim/frustum_box_cull_test_test.sv]
// Testbench for frustum_box_cull_test: loads planes and frustum corners, runs box
// tests and checks every answer against an in-bench predictor.
// Depends on fbc_pkg and the frustum_box_cull_test RTL.
module frustum_box_cull_test_test;
    timeunit 1ns;
    timeprecision 1ps;
    import fbc_pkg::*;

    localparam int NPL = 6;
    localparam int CW = 24;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic is_answer;
        logic visible;
    } answer_t;

    class cull_scoreboard;
        logic signed [CW-1:0] plane [NPL][4];
        logic signed [CW-1:0] corner [8][3];
        bit corner_en;
        answer_t pending[$];
        int mismatches;
        int answers;
        int culled;

        function new();
            corner_en = 1;
            mismatches = 0;
            answers = 0;
            culled = 0;
            foreach (plane[i, j]) plane[i][j] = '0;
            foreach (corner[i, j]) corner[i][j] = '0;
        endfunction

        function bit box_seen(logic signed [CW-1:0] mn[3], logic signed [CW-1:0] mx[3]);
            longint d;
            int outer;
            int above;
            int below;
            logic signed [CW-1:0] pt[3];
            for (int k = 0; k < NPL; k++)
            begin
                outer = 0;
                for (int c = 0; c < 8; c++)
                begin
                    for (int a = 0; a < 3; a++)
                        pt[a] = c[a] ? mx[a] : mn[a];
                    // products fit 48 bits, the sum fits 64
                    d = longint'(plane[k][0]) * longint'(pt[0])
                        + longint'(plane[k][1]) * longint'(pt[1])
                        + longint'(plane[k][2]) * longint'(pt[2])
                        + longint'(plane[k][3]) * 64'sd4096;
                    if (d >= 0) outer++;
                end
                if (outer == 8) return 0;
            end
            if (corner_en)
                for (int a = 0; a < 3; a++)
                begin
                    above = 0;
                    below = 0;
                    for (int c = 0; c < 8; c++)
                    begin
                        if (corner[c][a] > mx[a]) above++;
                        if (corner[c][a] < mn[a]) below++;
                    end
                    if (above == 8 || below == 8) return 0;
                end
            return 1;
        endfunction

        function void note_request(logic [1:0] op, logic [2:0] sl,
                                   logic signed [CW-1:0] p[3], logic signed [CW-1:0] off,
                                   logic signed [CW-1:0] q[3]);
            answer_t r;
            r = '0;
            if (op == OP_LOAD_PLANE)
            begin
                if (sl < NPL)
                begin
                    for (int a = 0; a < 3; a++) plane[sl][a] = p[a];
                    plane[sl][3] = off;
                end
            end
            else if (op == OP_LOAD_CORNER)
            begin
                for (int a = 0; a < 3; a++) corner[sl][a] = p[a];
            end
            else if (op == OP_TEST_BOX)
            begin
                r.is_answer = 1;
                r.visible = box_seen(p, q);
            end
            pending.push_back(r);
        endfunction

        function void check_answer(answer_t got);
            answer_t exp;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected answer %b/%b", got.is_answer, got.visible);
                return;
            end
            exp = pending.pop_front();
            if (exp.is_answer) answers++;
            if (exp.is_answer && !exp.visible) culled++;
            if (got !== exp)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: is_answer exp %b got %b, visible exp %b got %b",
                             exp.is_answer, got.is_answer, exp.visible, got.visible);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_wr_en = 0;
    logic cfg_wr_data = 0;
    logic in_valid = 0;
    logic in_stall;
    logic [OPCODE_W-1:0] opcode = '0;
    logic [SLOT_W-1:0] slot = '0;
    logic signed [CW-1:0] p_x = '0, p_y = '0, p_z = '0, plane_offset = '0;
    logic signed [CW-1:0] q_x = '0, q_y = '0, q_z = '0;
    logic out_valid;
    logic out_stall = 0;
    logic is_answer;
    logic visible;

    cull_scoreboard sb = new();
    int cycles = 0;
    int requests = 0;
    bit stall_mode = 0;

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    frustum_box_cull_test dut (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .slot(slot),
        .p_x(p_x), .p_y(p_y), .p_z(p_z), .plane_offset(plane_offset),
        .q_x(q_x), .q_y(q_y), .q_z(q_z), .out_valid(out_valid), .out_stall(out_stall),
        .is_answer(is_answer), .visible(visible)
    );

    // accepted requests and answers are observed at the edge
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && in_valid && !in_stall)
        begin
            sb.note_request(opcode, slot, '{p_x, p_y, p_z}, plane_offset, '{q_x, q_y, q_z});
            requests <= requests + 1;
        end
        if (rst_n && out_valid && !out_stall)
            sb.check_answer('{is_answer, visible});
        // receiver stall pattern: either busy spells or a quiet phase
        if (stall_mode)
            out_stall <= (($urandom_range(0, 9) < 4) ^ cycles[4]) && cycles[7];
        else
            out_stall <= 0;
        if (cycles == LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic signed [CW-1:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return CW'($urandom);
            default: return CW'(int'($urandom_range(0, 80000)) - 40000);
        endcase
    endfunction

    task automatic send(logic [1:0] op, logic [2:0] sl,
                        logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                        logic signed [CW-1:0] pz, logic signed [CW-1:0] off,
                        logic signed [CW-1:0] qx, logic signed [CW-1:0] qy,
                        logic signed [CW-1:0] qz);
        in_valid <= 1;
        opcode <= op;
        slot <= sl;
        p_x <= px; p_y <= py; p_z <= pz; plane_offset <= off;
        q_x <= qx; q_y <= qy; q_z <= qz;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic pause_sender();
        in_valid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (15) @(posedge clk);
    endtask

    task automatic set_corner_check(bit en);
        cfg_wr_en <= 1;
        cfg_wr_data <= en;
        @(posedge clk);
        cfg_wr_en <= 0;
        sb.corner_en = en;
    endtask

    task automatic load_frustum(bit random_content);
        for (int k = 0; k < NPL; k++)
            if (random_content)
                send(OP_LOAD_PLANE, 3'(k), rnd_coord(), rnd_coord(), rnd_coord(),
                     rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
            else
                // axis-aligned planes bounding a cube of half width 4.0
                send(OP_LOAD_PLANE, 3'(k), CW'((k == 0) ? 4096 : (k == 1) ? -4096 : 0),
                     CW'((k == 2) ? 4096 : (k == 3) ? -4096 : 0),
                     CW'((k == 4) ? 4096 : (k == 5) ? -4096 : 0), -16384, 0, 0, 0);
        for (int c = 0; c < 8; c++)
            send(OP_LOAD_CORNER, 3'(c), CW'(c[0] ? 16384 : -16384),
                 CW'(c[1] ? 16384 : -16384),
                 random_content ? rnd_coord() : CW'(c[2] ? 16384 : -16384), 0, 0, 0, 0);
    endtask

    task automatic random_box();
        logic signed [CW-1:0] mn[3];
        logic signed [CW-1:0] mx[3];
        for (int a = 0; a < 3; a++)
        begin
            mn[a] = ($urandom_range(0, 3) == 0) ? rnd_coord()
                    : CW'(int'($urandom_range(0, 65536)) - 40000);
            mx[a] = ($urandom_range(0, 7) == 0) ? rnd_coord()
                    : mn[a] + CW'($urandom_range(0, 30000));
        end
        send(OP_TEST_BOX, 3'($urandom), mn[0], mn[1], mn[2], rnd_coord(),
             mx[0], mx[1], mx[2]);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: known cube, inside, outside, touching, inverted and extreme boxes
        load_frustum(0);
        send(OP_LOAD_PLANE, 6, 24'sh7FFFFF, 24'sh800000, 1, 24'sh7FFFFF, 0, 0, 0);
        send(OP_LOAD_PLANE, 7, 0, 0, 0, 0, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
        send(OP_UNUSED, 7, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000, -1, -1, -1);
        send(OP_TEST_BOX, 0, -4096, -4096, -4096, 0, 4096, 4096, 4096);
        send(OP_TEST_BOX, 0, 20480, 0, 0, 0, 24576, 4096, 4096);
        send(OP_TEST_BOX, 0, 16384, 0, 0, 0, 20480, 4096, 4096);
        send(OP_TEST_BOX, 0, 4096, 4096, 4096, 0, -4096, -4096, -4096);
        send(OP_TEST_BOX, 7, 24'sh800000, 24'sh800000, 24'sh800000, 24'sh7FFFFF,
             24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        send(OP_TEST_BOX, 0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 0,
             24'sh800000, 24'sh800000, 24'sh800000);
        drain();
        set_corner_check(0);
        send(OP_TEST_BOX, 0, 20480, 0, 0, 0, 24576, 4096, 4096);
        send(OP_TEST_BOX, 0, -4096, -4096, -4096, 0, 4096, 4096, 4096);
        drain();

        // random phases, alternating the corner check and the idling style
        for (int ph = 0; ph < 8; ph++)
        begin
            set_corner_check(ph[0]);
            stall_mode = ph[1];
            load_frustum(ph != 0);
            for (int i = 0; i < 95; i++)
            begin
                if (ph[2] && $urandom_range(0, 5) == 0) pause_sender();
                case ($urandom_range(0, 11))
                    0: send(OP_LOAD_PLANE, 3'($urandom), rnd_coord(), rnd_coord(),
                            rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
                    1: send($urandom_range(0, 1) ? OP_LOAD_CORNER : OP_UNUSED, 3'($urandom),
                            rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                            rnd_coord(), rnd_coord(), rnd_coord());
                    default: random_box();
                endcase
            end
            drain();
        end
        set_corner_check(1);

        $display("Covered %0d requests, %0d box answers of which %0d culled.",
                 requests, sb.answers, sb.culled);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
